### design/ptp_pkg.sv
// Shared types, widths and helper functions for the point transform block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ptp_pkg;

	// Field and register widths.
	localparam int COORD_W       = 32;
	localparam int PROD_W        = 2 * COORD_W;
	localparam int CFG_W         = 64;
	localparam int CFG_IDX_W     = 4;
	localparam int NUM_CFG       = 8;
	localparam int CFG_SEL_W     = $clog2(NUM_CFG);
	localparam int FRAC_BITS_DEF = 16;

	// Three products and a shifted translation need 66 signed bits at most.
	localparam int ACC_W = 66;
	localparam int MAG_W = ACC_W - 1;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Divider: one compare stage, one stage per quotient bit, one saturation stage.
	localparam int DIV_STEPS = COORD_W;
	localparam int DIV_LAT   = DIV_STEPS + 2;

	localparam logic [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-1){1'b0}}};

	// Matrix register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0_COLS01 = 4'd0,
		REG_ROW0_COLS23 = 4'd1,
		REG_ROW1_COLS01 = 4'd2,
		REG_ROW1_COLS23 = 4'd3,
		REG_ROW2_COLS01 = 4'd4,
		REG_ROW2_COLS23 = 4'd5,
		REG_ROW3_COLS01 = 4'd6,
		REG_ROW3_COLS23 = 4'd7
	} cfg_reg_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic [MAG_W-1:0]          mag_t;

	// The four column sums of one point, passed from the front to the back.
	typedef struct packed {
		acc_t acc_x;
		acc_t acc_y;
		acc_t acc_z;
		acc_t acc_w;
	} col_sums_t;

	// Reset value of a matrix register: the identity matrix.
	function automatic logic [CFG_W-1:0] cfg_reset_value(input cfg_reg_t idx,
			input int frac_bits);
		logic [CFG_W-1:0] one;
		begin
			one = CFG_W'(1) << frac_bits;
			case (idx)
				REG_ROW0_COLS01: cfg_reset_value = one;
				REG_ROW1_COLS01: cfg_reset_value = one << COORD_W;
				REG_ROW2_COLS23: cfg_reset_value = one;
				REG_ROW3_COLS23: cfg_reset_value = one << COORD_W;
				default:         cfg_reset_value = '0;
			endcase
		end
	endfunction

	// Magnitude of a column sum; it always fits one bit narrower.
	function automatic mag_t acc_mag(input acc_t v);
		acc_t n;
		begin
			n = -v;
			acc_mag = v[ACC_W-1] ? mag_t'(n) : mag_t'(v);
		end
	endfunction

endpackage

`default_nettype wire

### design/ptp_front.sv
// Front part: matrix registers, input stage, products and column sums.
// Depends on ptp_pkg; feeds the queue in ptp_fifo.
`default_nettype none

module ptp_front import ptp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire coord_t               point_x,
	input  wire coord_t               point_y,
	input  wire coord_t               point_z,
	input  wire logic                 full,
	output logic                      push,
	output col_sums_t                 push_data
);

	logic [CFG_W-1:0] cfg_q [NUM_CFG];
	coord_t           coef [4][4];

	logic   en;
	logic   v_s1, v_s2, v_s3, v_s4;
	coord_t x_s1, y_s1, z_s1;
	logic signed [PROD_W-1:0] prod_s2 [4][3];
	coord_t trans_s2 [4];
	acc_t   pair_a_s3 [4];
	acc_t   pair_b_s3 [4];
	acc_t   acc_s4 [4];

	// Matrix registers; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				cfg_q[i] <= cfg_reset_value(cfg_reg_t'(CFG_IDX_W'(i)), FRAC_BITS);
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_CFG))) begin
			cfg_q[cfg_index[CFG_SEL_W-1:0]] <= cfg_wdata;
		end
	end

	// Split each register into its two signed coefficients.
	for (genvar r = 0; r < 4; r++) begin : g_row
		for (genvar c = 0; c < 4; c++) begin : g_col
			assign coef[r][c] = coord_t'(cfg_q[r*2 + c/2][(c%2)*COORD_W +: COORD_W]);
		end
	end

	// The whole front advances unless a finished word waits on a full queue.
	assign en       = !(v_s4 && full);
	assign in_stall = !en;
	assign push     = v_s4 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Input register, products, partial sums and final column sums.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= point_x;
			y_s1 <= point_y;
			z_s1 <= point_z;
			for (int c = 0; c < 4; c++) begin
				prod_s2[c][0] <= x_s1 * coef[0][c];
				prod_s2[c][1] <= y_s1 * coef[1][c];
				prod_s2[c][2] <= z_s1 * coef[2][c];
				trans_s2[c]   <= coef[3][c];
				pair_a_s3[c]  <= ACC_W'(prod_s2[c][0]) + ACC_W'(prod_s2[c][1]);
				pair_b_s3[c]  <= ACC_W'(prod_s2[c][2]) + (ACC_W'(trans_s2[c]) <<< FRAC_BITS);
				acc_s4[c]     <= pair_a_s3[c] + pair_b_s3[c];
			end
		end
	end

	assign push_data.acc_x = acc_s4[0];
	assign push_data.acc_y = acc_s4[1];
	assign push_data.acc_z = acc_s4[2];
	assign push_data.acc_w = acc_s4[3];

`ifndef SYNTH
	// A finished word that could not be queued is still there next cycle.
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !push) |=> v_s4)
		else $error("front: last stage lost a word while blocked");
`endif

endmodule

`default_nettype wire

### design/ptp_fifo.sv
// Short queue of column sums between the front and the back.
// Depends on ptp_pkg for the word type and depth.
`default_nettype none

module ptp_fifo import ptp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire col_sums_t push_data,
	output logic           full,
	input  wire logic      pop,
	output logic           empty,
	output col_sums_t      head
);

	col_sums_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue: fill count beyond depth");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("queue: push when full or pop when empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue: fill count did not follow a push");
`endif

endmodule

`default_nettype wire

### design/ptp_divider.sv
// Pipelined fixed-point divider: one quotient bit per stage, then saturation.
// Depends on ptp_pkg; instantiated three times by ptp_back.
`default_nettype none

module ptp_divider import ptp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire mag_t               num_mag,
	input  wire mag_t               den_mag,
	input  wire logic               neg,
	input  wire logic               zero,
	output logic [COORD_W-1:0]      quot
);

	localparam int SHIFT  = COORD_W - FRAC_BITS;
	localparam int WIDE_W = MAG_W + COORD_W;

	mag_t               rem_s  [DIV_STEPS+1];
	mag_t               den_s  [DIV_STEPS+1];
	logic [COORD_W-1:0] nlow_s [DIV_STEPS+1];
	logic [COORD_W-1:0] q_s    [DIV_STEPS+1];
	logic               neg_s  [DIV_STEPS+1];
	logic               zero_s [DIV_STEPS+1];
	logic               ovf_s  [DIV_STEPS+1];
	logic [COORD_W-1:0] sat_val;
	logic [COORD_W-1:0] quot_q;

	// First stage: overflow when the quotient needs more than 32 bits,
	// and the starting remainder from the top of the scaled numerator.
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0]  <= WIDE_W'(num_mag) >= (WIDE_W'(den_mag) << SHIFT);
			rem_s[0]  <= num_mag >> SHIFT;
			nlow_s[0] <= COORD_W'(num_mag << FRAC_BITS);
			den_s[0]  <= den_mag;
			q_s[0]    <= '0;
			neg_s[0]  <= neg;
			zero_s[0] <= zero;
		end
	end

	// One restoring step per stage.
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [MAG_W:0] trial;
		logic [MAG_W:0] diff;
		logic           ge;

		always_comb begin
			trial = {rem_s[k-1], nlow_s[k-1][COORD_W-1]};
			ge    = trial >= {1'b0, den_s[k-1]};
			diff  = trial - {1'b0, den_s[k-1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? MAG_W'(diff) : MAG_W'(trial);
				nlow_s[k] <= nlow_s[k-1] << 1;
				q_s[k]    <= {q_s[k-1][COORD_W-2:0], ge};
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				zero_s[k] <= zero_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
			end
		end
	end

	// Sign and saturation.
	always_comb begin
		if (zero_s[DIV_STEPS]) begin
			sat_val = '0;
		end else if (!neg_s[DIV_STEPS]) begin
			sat_val = (ovf_s[DIV_STEPS] || q_s[DIV_STEPS][COORD_W-1]) ? SAT_POS
				: q_s[DIV_STEPS];
		end else begin
			sat_val = (ovf_s[DIV_STEPS] || (q_s[DIV_STEPS] > SAT_NEG)) ? SAT_NEG
				: (COORD_W'(0) - q_s[DIV_STEPS]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot_q <= sat_val;
		end
	end

	assign quot = quot_q;

endmodule

`default_nettype wire

### design/ptp_back.sv
// Back part: takes column sums from the queue, divides x, y and z by w.
// Depends on ptp_pkg and ptp_divider.
`default_nettype none

module ptp_back import ptp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      empty,
	input  wire col_sums_t head,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_stall,
	output coord_t         proj_x,
	output coord_t         proj_y,
	output coord_t         proj_z,
	output logic           w_is_zero
);

	logic               back_en;
	logic               v_s1;
	mag_t               num_s1 [3];
	logic               neg_s1 [3];
	mag_t               den_s1;
	logic               zero_s1;
	logic               vpipe_q [DIV_LAT];
	logic               zpipe_q [DIV_LAT];
	logic [COORD_W-1:0] quot [3];

	// The back moves as one unless a result waits on a stalled output.
	assign back_en   = !vpipe_q[DIV_LAT-1] || !out_stall;
	assign pop       = back_en && !empty;
	assign out_valid = vpipe_q[DIV_LAT-1];
	assign w_is_zero = zpipe_q[DIV_LAT-1];

	// Valid bits of the back pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				vpipe_q[i] <= 1'b0;
			end
		end else if (back_en) begin
			v_s1       <= pop;
			vpipe_q[0] <= v_s1;
			for (int i = 1; i < DIV_LAT; i++) begin
				vpipe_q[i] <= vpipe_q[i-1];
			end
		end
	end

	// Magnitudes, quotient signs and the zero-w flag.
	always_ff @(posedge clk) begin
		if (back_en) begin
			num_s1[0]  <= acc_mag(head.acc_x);
			num_s1[1]  <= acc_mag(head.acc_y);
			num_s1[2]  <= acc_mag(head.acc_z);
			neg_s1[0]  <= head.acc_x[ACC_W-1] ^ head.acc_w[ACC_W-1];
			neg_s1[1]  <= head.acc_y[ACC_W-1] ^ head.acc_w[ACC_W-1];
			neg_s1[2]  <= head.acc_z[ACC_W-1] ^ head.acc_w[ACC_W-1];
			den_s1     <= acc_mag(head.acc_w);
			zero_s1    <= (head.acc_w == '0);
			zpipe_q[0] <= zero_s1;
			for (int i = 1; i < DIV_LAT; i++) begin
				zpipe_q[i] <= zpipe_q[i-1];
			end
		end
	end

	// One divider per output coordinate.
	for (genvar j = 0; j < 3; j++) begin : g_div
		ptp_divider #(
			.FRAC_BITS(FRAC_BITS)
		) u_div (
			.clk     (clk),
			.en      (back_en),
			.num_mag (num_s1[j]),
			.den_mag (den_s1),
			.neg     (neg_s1[j]),
			.zero    (zero_s1),
			.quot    (quot[j])
		);
	end

	assign proj_x = coord_t'(quot[0]);
	assign proj_y = coord_t'(quot[1]);
	assign proj_z = coord_t'(quot[2]);

`ifndef SYNTH
	a_zero_w_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && w_is_zero) |-> ((proj_x == '0) && (proj_y == '0) && (proj_z == '0)))
		else $error("back: nonzero result with zero w");
`endif

endmodule

`default_nettype wire

### design/point_transform_perspective.sv
// A result word is presented after its point has passed the 4 front stages,
// the queue, 1 back input stage and the 34 divider stages.
// Throughput: one point per cycle unless stalled, set by the pipelined one-bit-per-stage dividers.
// Stalls on the output hold the back; the 4-word queue lets the front keep going.
// Reset (arst_n low, asynchronous) empties the pipeline and queue and loads
// the identity matrix into the eight matrix registers.
`default_nettype none

module point_transform_perspective import ptp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire coord_t               point_x,
	input  wire coord_t               point_y,
	input  wire coord_t               point_z,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output coord_t                    proj_x,
	output coord_t                    proj_y,
	output coord_t                    proj_z,
	output logic                      w_is_zero
);

	logic      push, full, pop, empty;
	col_sums_t push_data, head;

	ptp_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	ptp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	ptp_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.proj_x    (proj_x),
		.proj_y    (proj_y),
		.proj_z    (proj_z),
		.w_is_zero (w_is_zero)
	);

endmodule

`default_nettype wire
